FILE: hdl/bpc_pkg.sv
package bpc_pkg;

  // Fixed-point format: unsigned, 24 fraction bits, one integer bit for 1.0
  localparam int FRAC_BITS = 24;
  localparam int Q_BITS    = FRAC_BITS + 1;
  localparam logic [Q_BITS-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  // Polynomial weights of the first two channels
  localparam int FIRST_COEF  = 18;
  localparam int SECOND_COEF = 144;

  // Register widths and reset values
  localparam int LIMIT_BITS     = 16;
  localparam int WEIGHT_BITS    = 8;
  localparam int CFG_INDEX_BITS = 3;
  localparam int MAX_ITER_RESET = 100;
  localparam int GAIN_RESET     = 255;
  localparam int WEIGHT_RESET   = 9;

  // Default parameter values
  localparam int COUNT_BITS_DEF = 16;
  localparam int GAIN_BITS_DEF  = 8;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MAX_ITER     = 3'd0,
    REG_GAIN_FIRST   = 3'd1,
    REG_GAIN_SECOND  = 3'd2,
    REG_GAIN_THIRD   = 3'd3,
    REG_THIRD_WEIGHT = 3'd4
  } cfg_reg_t;

  // Control that travels alongside each pipeline stage
  typedef struct packed {
    logic valid;
    logic in_set;
  } bpc_tag_t;

  // Q24 product, truncated: floor(a * b / 2^24)
  function automatic logic [Q_BITS-1:0] qmul(input logic [Q_BITS-1:0] a,
                                             input logic [Q_BITS-1:0] b);
    logic [2*Q_BITS-1:0] prod;
    prod = {{Q_BITS{1'b0}}, a} * {{Q_BITS{1'b0}}, b};
    return prod[FRAC_BITS +: Q_BITS];
  endfunction

endpackage

FILE: hdl/bpc_divider.sv
module bpc_divider
  import bpc_pkg::*;
#(
  parameter int LIM_BITS = LIMIT_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  bpc_tag_t             in_tag,
  input  logic [LIM_BITS-1:0]  in_rem,
  input  logic [LIM_BITS-1:0]  limit,
  output bpc_tag_t             out_tag,
  output logic [FRAC_BITS-1:0] out_quot
);

  // One restoring-division step per stage: stage i gives quotient bit 23-i of count*2^24/limit
  bpc_tag_t             tag_q  [FRAC_BITS];
  logic [LIM_BITS-1:0]  rem_q  [FRAC_BITS];
  logic [FRAC_BITS-1:0] quot_q [FRAC_BITS];

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_step
    bpc_tag_t             tag_prev;
    logic [LIM_BITS-1:0]  rem_prev;
    logic [FRAC_BITS-1:0] quot_prev;
    logic [LIM_BITS:0]    shifted;
    logic [LIM_BITS:0]    diff;
    logic                 ge;

    if (i == 0) begin : g_first
      assign tag_prev  = in_tag;
      assign rem_prev  = in_rem;
      assign quot_prev = '0;
    end else begin : g_rest
      assign tag_prev  = tag_q[i-1];
      assign rem_prev  = rem_q[i-1];
      assign quot_prev = quot_q[i-1];
    end

    // shift in a zero, subtract the divisor when it fits
    assign shifted = {rem_prev, 1'b0};
    assign ge      = shifted >= {1'b0, limit};
    assign diff    = shifted - {1'b0, limit};

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_q[i] <= '0;
      end else if (en) begin
        tag_q[i] <= tag_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i]  <= ge ? diff[LIM_BITS-1:0] : shifted[LIM_BITS-1:0];
        quot_q[i] <= {quot_prev[FRAC_BITS-2:0], ge};
      end
    end
  end

  assign out_tag  = tag_q[FRAC_BITS-1];
  assign out_quot = quot_q[FRAC_BITS-1];

endmodule

FILE: hdl/bernstein_palette_colorizer_core.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     iteration_count
// out       output     out_valid / out_ready   channel_first/second/third, inside_set
// cfg       input      cfg_write_en            cfg_index, cfg_data
//
// One pixel per cycle sustained while out is not stalled; the result passes through
// 30 register stages: entry, 24 divider stages, 4 polynomial stages, output.
// The 24-stage bit-per-stage divider for count/limit sets the latency.
// rst is synchronous and clears the valid bits and configuration registers.
// A stall on out freezes every stage at once; in_ready follows that enable.
module bernstein_palette_colorizer_core
  import bpc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int GAIN_BITS  = GAIN_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COUNT_BITS-1:0] iteration_count,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            channel_first,
  output logic [7:0]            channel_second,
  output logic [7:0]            channel_third,
  output logic                  inside_set,
  input  logic                  cfg_write_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [((GAIN_BITS > LIMIT_BITS) ? GAIN_BITS : LIMIT_BITS)-1:0] cfg_data
);

  localparam int LIM_BITS   = (COUNT_BITS < LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
  localparam int SCALE_BITS = GAIN_BITS + 8;
  localparam int PROD_BITS  = Q_BITS + SCALE_BITS;

  // Channel byte: bits 31..24 of p * scale
  function automatic logic [7:0] to_byte(input logic [Q_BITS-1:0] p,
                                         input logic [SCALE_BITS-1:0] scale);
    logic [PROD_BITS-1:0] prod;
    prod = {{SCALE_BITS{1'b0}}, p} * {{Q_BITS{1'b0}}, scale};
    return prod[FRAC_BITS +: 8];
  endfunction

  // Configuration registers
  logic [LIMIT_BITS-1:0]  max_iterations;
  logic [GAIN_BITS-1:0]   gain_first;
  logic [GAIN_BITS-1:0]   gain_second;
  logic [GAIN_BITS-1:0]   gain_third;
  logic [WEIGHT_BITS-1:0] third_weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= LIMIT_BITS'(MAX_ITER_RESET);
      gain_first     <= GAIN_BITS'(GAIN_RESET);
      gain_second    <= GAIN_BITS'(GAIN_RESET);
      gain_third     <= GAIN_BITS'(GAIN_RESET);
      third_weight   <= WEIGHT_BITS'(WEIGHT_RESET);
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_MAX_ITER:     max_iterations <= cfg_data[LIMIT_BITS-1:0];
        REG_GAIN_FIRST:   gain_first     <= cfg_data[GAIN_BITS-1:0];
        REG_GAIN_SECOND:  gain_second    <= cfg_data[GAIN_BITS-1:0];
        REG_GAIN_THIRD:   gain_third     <= cfg_data[GAIN_BITS-1:0];
        REG_THIRD_WEIGHT: third_weight   <= cfg_data[WEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Per-channel scale factors, registered off the config
  logic [SCALE_BITS-1:0] scale_first;
  logic [SCALE_BITS-1:0] scale_second;
  logic [SCALE_BITS-1:0] scale_third;

  always_ff @(posedge clk) begin
    scale_first  <= SCALE_BITS'(gain_first) * SCALE_BITS'(FIRST_COEF);
    scale_second <= SCALE_BITS'(gain_second) * SCALE_BITS'(SECOND_COEF);
    scale_third  <= SCALE_BITS'(gain_third) * SCALE_BITS'(third_weight);
  end

  // Global pipeline enable: advance unless a result is held
  logic pipe_en;
  logic [LIM_BITS-1:0] limit;

  assign pipe_en  = !out_valid || out_ready;
  assign in_ready = pipe_en;
  assign limit    = max_iterations[LIM_BITS-1:0];

  // Entry stage: in-set test
  bpc_tag_t            ent_tag;
  logic [LIM_BITS-1:0] ent_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_tag <= '0;
    end else if (pipe_en) begin
      ent_tag <= '{valid: in_valid, in_set: iteration_count >= COUNT_BITS'(limit)};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      ent_rem <= iteration_count[LIM_BITS-1:0];
    end
  end

  // k = count * 2^24 / limit
  bpc_tag_t             div_tag;
  logic [FRAC_BITS-1:0] div_k;

  bpc_divider #(
    .LIM_BITS(LIM_BITS)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .en       (pipe_en),
    .in_tag   (ent_tag),
    .in_rem   (ent_rem),
    .limit    (limit),
    .out_tag  (div_tag),
    .out_quot (div_k)
  );

  // Polynomial stages
  bpc_tag_t          s1_tag, s2_tag, s3_tag, s4_tag;
  logic [Q_BITS-1:0] s1_k, s1_m;
  logic [Q_BITS-1:0] s2_k, s2_m, s2_k2, s2_m2;
  logic [Q_BITS-1:0] s3_k, s3_m, s3_k3, s3_m3, s3_p2;
  logic [Q_BITS-1:0] s4_p1, s4_p2, s4_p3;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag <= '0;
      s2_tag <= '0;
      s3_tag <= '0;
      s4_tag <= '0;
    end else if (pipe_en) begin
      s1_tag <= div_tag;
      s2_tag <= s1_tag;
      s3_tag <= s2_tag;
      s4_tag <= s3_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      // m = 1 - k
      s1_k  <= {1'b0, div_k};
      s1_m  <= ONE_Q - {1'b0, div_k};
      // squares
      s2_k  <= s1_k;
      s2_m  <= s1_m;
      s2_k2 <= qmul(s1_k, s1_k);
      s2_m2 <= qmul(s1_m, s1_m);
      // cubes and the second channel term
      s3_k  <= s2_k;
      s3_m  <= s2_m;
      s3_k3 <= qmul(s2_k2, s2_k);
      s3_m3 <= qmul(s2_m2, s2_m);
      s3_p2 <= qmul(s2_m2, s2_k2);
      // first and third channel terms
      s4_p1 <= qmul(s3_m, s3_k3);
      s4_p2 <= s3_p2;
      s4_p3 <= qmul(s3_m3, s3_k);
    end
  end

  // Output register: scale, wrap to a byte, black when in the set
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pipe_en) begin
      out_valid <= s4_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      inside_set     <= s4_tag.in_set;
      channel_first  <= s4_tag.in_set ? 8'd0 : to_byte(s4_p1, scale_first);
      channel_second <= s4_tag.in_set ? 8'd0 : to_byte(s4_p2, scale_second);
      channel_third  <= s4_tag.in_set ? 8'd0 : to_byte(s4_p3, scale_third);
    end
  end

  // Checks
  a_inside_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && inside_set |->
      channel_first == 8'd0 && channel_second == 8'd0 && channel_third == 8'd0)
    else $error("inside-set result carries nonzero color");

  a_stall_only_when_held: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result held");

  a_result_from_advance: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pipe_en))
    else $error("result appeared without pipeline advance");

endmodule

FILE: tb/sv/bpc_color_checker.sv
`timescale 1ns / 100ps

// Watches the pixel, color and register channels, predicts each color from
// its own copy of the registers and compares results in order.
module bpc_color_checker
  import bpc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int GAIN_BITS  = GAIN_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [COUNT_BITS-1:0] iteration_count,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [7:0]            channel_first,
  input  logic [7:0]            channel_second,
  input  logic [7:0]            channel_third,
  input  logic                  inside_set,
  input  logic                  cfg_write_en,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [((GAIN_BITS > LIMIT_BITS) ? GAIN_BITS : LIMIT_BITS)-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    pending_count
);

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] third;
    logic       in_set;
  } color_t;

  localparam int REPORT_LIMIT = 10;

  // Shadow copy of the register file
  logic [LIMIT_BITS-1:0]  limit_reg       = LIMIT_BITS'(MAX_ITER_RESET);
  logic [GAIN_BITS-1:0]   gain_first_reg  = GAIN_BITS'(GAIN_RESET);
  logic [GAIN_BITS-1:0]   gain_second_reg = GAIN_BITS'(GAIN_RESET);
  logic [GAIN_BITS-1:0]   gain_third_reg  = GAIN_BITS'(GAIN_RESET);
  logic [WEIGHT_BITS-1:0] weight_reg      = WEIGHT_BITS'(WEIGHT_RESET);

  // Colors predicted for accepted pixels, oldest first
  color_t pending_colors[$];

  // Q24 product, truncated
  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> FRAC_BITS;
  endfunction

  // Scale a Q24 value, truncate and keep the low byte
  function automatic logic [7:0] fx_byte(input logic [63:0] q, input logic [63:0] scale);
    logic [63:0] prod;
    prod = (q * scale) >> FRAC_BITS;
    return prod[7:0];
  endfunction

  function automatic color_t bernstein_color(input logic [COUNT_BITS-1:0] count);
    color_t      c;
    logic [63:0] cnt, lim, k, m, k2, k3, m2, m3, s1, s2, s3;
    c   = '0;
    cnt = 64'(count);
    lim = 64'(limit_reg) & ((64'd1 << COUNT_BITS) - 64'd1);
    // at or past the limit (a zero limit included): black, no division
    if (cnt >= lim) begin
      c.in_set = 1'b1;
      return c;
    end
    k  = (cnt << FRAC_BITS) / lim;
    m  = (64'd1 << FRAC_BITS) - k;
    k2 = fx_mul(k, k);
    k3 = fx_mul(k2, k);
    m2 = fx_mul(m, m);
    m3 = fx_mul(m2, m);
    s1 = 64'(FIRST_COEF) * 64'(gain_first_reg);
    s2 = 64'(SECOND_COEF) * 64'(gain_second_reg);
    s3 = 64'(weight_reg) * 64'(gain_third_reg);
    c.first  = fx_byte(fx_mul(m, k3), s1);
    c.second = fx_byte(fx_mul(m2, k2), s2);
    c.third  = fx_byte(fx_mul(m3, k), s3);
    return c;
  endfunction

  always @(posedge clk) begin : monitor
    color_t want;
    color_t seen;
    if (rst) begin
      limit_reg       <= LIMIT_BITS'(MAX_ITER_RESET);
      gain_first_reg  <= GAIN_BITS'(GAIN_RESET);
      gain_second_reg <= GAIN_BITS'(GAIN_RESET);
      gain_third_reg  <= GAIN_BITS'(GAIN_RESET);
      weight_reg      <= WEIGHT_BITS'(WEIGHT_RESET);
      pending_colors.delete();
      mismatch_count = 0;
    end else begin
      // register writes; unmapped indexes are dropped
      if (cfg_write_en) begin
        case (cfg_index)
          REG_MAX_ITER:     limit_reg       <= cfg_data[LIMIT_BITS-1:0];
          REG_GAIN_FIRST:   gain_first_reg  <= cfg_data[GAIN_BITS-1:0];
          REG_GAIN_SECOND:  gain_second_reg <= cfg_data[GAIN_BITS-1:0];
          REG_GAIN_THIRD:   gain_third_reg  <= cfg_data[GAIN_BITS-1:0];
          REG_THIRD_WEIGHT: weight_reg      <= cfg_data[WEIGHT_BITS-1:0];
          default: ;
        endcase
      end

      // pixel transfer: predict its color
      if (in_valid && in_ready) begin
        pending_colors.push_back(bernstein_color(iteration_count));
      end

      // color transfer: compare with the oldest prediction
      if (out_valid && out_ready) begin
        seen = '{channel_first, channel_second, channel_third, inside_set};
        if (pending_colors.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: color result with no pixel pending:", $realtime,
                     " first=%0d second=%0d third=%0d in_set=%0b",
                     seen.first, seen.second, seen.third, seen.in_set);
          end
        end else begin
          want = pending_colors.pop_front();
          if (want.first !== seen.first || want.second !== seen.second ||
              want.third !== seen.third || want.in_set !== seen.in_set) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("%0t: color mismatch: want first=%0d second=%0d third=%0d in_set=%0b",
                       $realtime, want.first, want.second, want.third, want.in_set);
              $display("%0t:                 got  first=%0d second=%0d third=%0d in_set=%0b",
                       $realtime, seen.first, seen.second, seen.third, seen.in_set);
            end
          end
        end
      end
    end
    pending_count = pending_colors.size();
  end

endmodule

FILE: tb/sv/tb_bernstein_palette_colorizer_core.sv
`timescale 1ns / 100ps

module tb_bernstein_palette_colorizer_core;
  import bpc_pkg::*;

  localparam int COUNT_BITS      = COUNT_BITS_DEF;
  localparam int GAIN_BITS       = GAIN_BITS_DEF;
  localparam int CFG_BITS        = (GAIN_BITS > LIMIT_BITS) ? GAIN_BITS : LIMIT_BITS;
  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 40;
  localparam int BLOCK_ITEMS     = 112;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [COUNT_BITS-1:0]     iteration_count = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [7:0]                channel_first;
  logic [7:0]                channel_second;
  logic [7:0]                channel_third;
  logic                      inside_set;
  logic                      cfg_write_en = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_MAX_ITER;
  logic [CFG_BITS-1:0]       cfg_data = '0;

  int                        mismatch_count;
  int                        pending_count;
  int                        send_idle_pct = 6;
  int                        recv_idle_pct = 79;
  logic                      hold_off_req = 1'b0;
  int                        quiet_cycles = 0;
  logic [LIMIT_BITS-1:0]     cur_limit = LIMIT_BITS'(MAX_ITER_RESET);

  bernstein_palette_colorizer_core #(
    .COUNT_BITS(COUNT_BITS),
    .GAIN_BITS (GAIN_BITS)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .iteration_count(iteration_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .channel_first  (channel_first),
    .channel_second (channel_second),
    .channel_third  (channel_third),
    .inside_set     (inside_set),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  bpc_color_checker #(
    .COUNT_BITS(COUNT_BITS),
    .GAIN_BITS (GAIN_BITS)
  ) u_color_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .iteration_count(iteration_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .channel_first  (channel_first),
    .channel_second (channel_second),
    .channel_third  (channel_third),
    .inside_set     (inside_set),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Color sink: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one pixel; called and returns at a falling edge
  task automatic send_count(input logic [COUNT_BITS-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid        = 1'b1;
    iteration_count = value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the source until every predicted color has come back
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all registers back to back, then a stray write to an unmapped index
  task automatic apply_settings(input logic [LIMIT_BITS-1:0] limit,
                                input logic [GAIN_BITS-1:0] g1,
                                input logic [GAIN_BITS-1:0] g2,
                                input logic [GAIN_BITS-1:0] g3,
                                input logic [WEIGHT_BITS-1:0] weight);
    cfg_write_en = 1'b1;
    cfg_index = REG_MAX_ITER;     cfg_data = CFG_BITS'(limit);  @(negedge clk);
    cfg_index = REG_GAIN_FIRST;   cfg_data = CFG_BITS'(g1);     @(negedge clk);
    cfg_index = REG_GAIN_SECOND;  cfg_data = CFG_BITS'(g2);     @(negedge clk);
    cfg_index = REG_GAIN_THIRD;   cfg_data = CFG_BITS'(g3);     @(negedge clk);
    cfg_index = REG_THIRD_WEIGHT; cfg_data = CFG_BITS'(weight); @(negedge clk);
    cfg_index = CFG_INDEX_BITS'($urandom_range((1 << CFG_INDEX_BITS) - 1,
                                               REG_THIRD_WEIGHT + 1));
    cfg_data  = CFG_BITS'($urandom);
    @(negedge clk);
    cfg_write_en = 1'b0;
    cur_limit    = limit;
  endtask

  // Extremes are weighted up
  function automatic logic [7:0] random_byte();
    case ($urandom_range(3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_settings();
    logic [LIMIT_BITS-1:0] limit;
    case ($urandom_range(3))
      0:       limit = LIMIT_BITS'($urandom_range(16, 1));
      1:       limit = LIMIT_BITS'($urandom_range(1000, 2));
      2:       limit = LIMIT_BITS'($urandom_range(65535, 1));
      default: limit = '1;
    endcase
    apply_settings(limit, GAIN_BITS'(random_byte()), GAIN_BITS'(random_byte()),
                   GAIN_BITS'(random_byte()), random_byte());
  endtask

  // Mostly counts up to the limit, some at it, some anywhere
  function automatic logic [COUNT_BITS-1:0] random_count(input logic [LIMIT_BITS-1:0] limit);
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 7) return COUNT_BITS'($urandom_range(limit));
    if (pick == 7) return COUNT_BITS'(limit);
    return COUNT_BITS'($urandom);
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset register values: around the limit of 100 and both count extremes
    send_count(0);
    send_count(1);
    send_count(50);
    send_count(99);
    send_count(100);
    send_count(101);
    send_count('1);

    // zero limit: everything is black
    wait_drained();
    apply_settings(0, 8'd255, 8'd255, 8'd255, 8'd255);
    send_count(0);
    send_count(1);
    send_count('1);

    // widest limit with full gains and weight, channels wrap
    wait_drained();
    apply_settings('1, 8'd255, 8'd255, 8'd255, 8'd255);
    send_count(1);
    send_count(16384);
    send_count(32768);
    send_count(49152);
    send_count(65534);
    send_count('1);

    // limit of one, all gains zero
    wait_drained();
    apply_settings(1, 8'd0, 8'd0, 8'd0, 8'd0);
    send_count(0);
    send_count(1);

    // mixed gains
    wait_drained();
    apply_settings(7, 8'd0, 8'd255, 8'd1, 8'd0);
    send_count(3);
    send_count(5);

    // random part: three back-pressure profiles, new settings per block
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 6;  recv_idle_pct = 79; end
        1: begin send_idle_pct = 79; recv_idle_pct = 6;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int blk = 0; blk < 3; blk++) begin
        wait_drained();
        random_settings();
        // fill the pipe against a stalled sink at least once
        if (phase == 2 && blk == 1) hold_off_req = 1'b1;
        for (int n = 0; n < BLOCK_ITEMS; n++) begin
          send_count(random_count(cur_limit));
        end
      end
    end

    wait_drained();
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
